[rtl/core/ipsd_pkg.sv]
// shared constants, types and the sine table of the inverse park / svpwm duty core
package ipsd_pkg;

    // field widths
    localparam int ANGLE_W  = 16;
    localparam int VOLT_W   = 16;
    localparam int TRIG_W   = 16;   // signed q1.14 sine and cosine
    localparam int PROD_W   = 32;   // voltage times trig
    localparam int AB_W     = 18;   // alpha and beta in q.8 volts
    localparam int GAIN_W   = 24;   // counts per volt, unsigned q16.8
    localparam int PER_W    = 16;
    localparam int AK_W     = 43;   // alpha or beta times gain
    localparam int UQ_W     = 38;   // sign test terms in q.24
    localparam int SA_W     = 60;   // sqrt(3)/2 times alpha times gain
    localparam int XYZ_W    = 62;   // x, y, z times in q.32 counts
    localparam int NUM_W    = 64;   // compare numerators
    localparam int DUTY_W   = 16;
    localparam int CODE_W   = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_DATA_W  = 24;

    // sqrt(3)/2 in q0.16
    localparam logic [16:0] SQRT3_HALF_Q16 = 17'd56756;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 24'd77594;
    localparam logic [PER_W-1:0]  PERIOD_RESET = 16'd4200;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_COUNTS_PER_VOLT = 1'b0,
        CFG_PWM_PERIOD      = 1'b1
    } cfg_index_t;

    // sector codes, bit0 beta > 0, bit1 u2 > 0, bit2 u3 > 0
    localparam logic [CODE_W-1:0] SEC_CODE_1 = 3'd1;
    localparam logic [CODE_W-1:0] SEC_CODE_2 = 3'd2;
    localparam logic [CODE_W-1:0] SEC_CODE_3 = 3'd3;
    localparam logic [CODE_W-1:0] SEC_CODE_4 = 3'd4;
    localparam logic [CODE_W-1:0] SEC_CODE_5 = 3'd5;
    localparam logic [CODE_W-1:0] SEC_CODE_6 = 3'd6;

    // quarter wave of round(16384 * sin(k * pi / 128)), k = 0..64
    localparam logic [14:0] SIN_QUARTER [0:64] = '{
        15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
        15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
        15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
        15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
        15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
        15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978,
        15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
        15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
        15'd16384
    };

    // full wave sine from an 8 bit angle index, signed q1.14
    function automatic logic signed [TRIG_W-1:0] sin_of(input logic [7:0] idx);
        logic [1:0]  quad;
        logic [6:0]  pos;
        logic [14:0] mag;
        logic signed [TRIG_W-1:0] mag_s;
        quad = idx[7:6];
        pos  = {1'b0, idx[5:0]};
        if (quad[0]) begin
            mag = SIN_QUARTER[7'd64 - pos];
        end else begin
            mag = SIN_QUARTER[pos];
        end
        mag_s = $signed({1'b0, mag});
        return quad[1] ? -mag_s : mag_s;
    endfunction

endpackage

[rtl/core/ipsd_rot.sv]
// sine and cosine lookup and inverse park rotation to alpha and beta
module ipsd_rot (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [ipsd_pkg::ANGLE_W-1:0]          elec_angle,
    input  logic signed [ipsd_pkg::VOLT_W-1:0]    volt_d,
    input  logic signed [ipsd_pkg::VOLT_W-1:0]    volt_q,
    output logic                                  out_valid,
    output logic signed [ipsd_pkg::AB_W-1:0]      alpha,
    output logic signed [ipsd_pkg::AB_W-1:0]      beta
);

    logic [2:0] valid_reg;

    logic signed [ipsd_pkg::TRIG_W-1:0] sn_reg, cs_reg;
    logic signed [ipsd_pkg::VOLT_W-1:0] ud_reg, uq_reg;
    logic signed [ipsd_pkg::PROD_W-1:0] p_dc_reg, p_qs_reg, p_qc_reg, p_ds_reg;
    logic signed [ipsd_pkg::AB_W-1:0]   alpha_reg, beta_reg;

    logic signed [ipsd_pkg::TRIG_W-1:0] sn_next, cs_next;
    logic signed [ipsd_pkg::PROD_W:0]   alpha_sum, beta_sum;

    // table lookup, cosine is the sine a quarter turn ahead
    always_comb begin
        sn_next = ipsd_pkg::sin_of(elec_angle[15:8]);
        cs_next = ipsd_pkg::sin_of(elec_angle[15:8] + 8'd64);
    end

    // rotation sums with round half up before dropping 14 fraction bits
    always_comb begin
        alpha_sum = $signed({p_dc_reg[ipsd_pkg::PROD_W-1], p_dc_reg})
                  - $signed({p_qs_reg[ipsd_pkg::PROD_W-1], p_qs_reg})
                  + 33'sd8192;
        beta_sum  = $signed({p_qc_reg[ipsd_pkg::PROD_W-1], p_qc_reg})
                  + $signed({p_ds_reg[ipsd_pkg::PROD_W-1], p_ds_reg})
                  + 33'sd8192;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (en) begin
            sn_reg    <= sn_next;
            cs_reg    <= cs_next;
            ud_reg    <= volt_d;
            uq_reg    <= volt_q;
            p_dc_reg  <= ud_reg * cs_reg;
            p_qs_reg  <= uq_reg * sn_reg;
            p_qc_reg  <= uq_reg * cs_reg;
            p_ds_reg  <= ud_reg * sn_reg;
            alpha_reg <= alpha_sum[31:14];
            beta_reg  <= beta_sum[31:14];
        end
    end

    assign out_valid = valid_reg[2];
    assign alpha     = alpha_reg;
    assign beta      = beta_reg;

endmodule

[rtl/core/ipsd_scale.sv]
// sector sign tests and gain scaling of the x, y and z times
module ipsd_scale (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [ipsd_pkg::AB_W-1:0]      alpha,
    input  logic signed [ipsd_pkg::AB_W-1:0]      beta,
    input  logic [ipsd_pkg::GAIN_W-1:0]           counts_per_volt,
    output logic                                  out_valid,
    output logic [ipsd_pkg::CODE_W-1:0]           sector_code,
    output logic signed [ipsd_pkg::XYZ_W-1:0]     x_time,
    output logic signed [ipsd_pkg::XYZ_W-1:0]     y_time,
    output logic signed [ipsd_pkg::XYZ_W-1:0]     z_time
);

    logic [2:0] valid_reg;

    logic signed [ipsd_pkg::AK_W-1:0]  ak_reg, bk_reg, bk2_reg;
    logic signed [ipsd_pkg::SA_W-1:0]  sa_reg;
    logic [ipsd_pkg::CODE_W-1:0]       code_reg, code2_reg, code3_reg;
    logic signed [ipsd_pkg::XYZ_W-1:0] x_reg, y_reg, z_reg;

    logic signed [ipsd_pkg::GAIN_W:0]  gain_s;
    logic signed [ipsd_pkg::UQ_W-1:0]  s_alpha, half_beta, zq24, yq24;
    logic [ipsd_pkg::CODE_W-1:0]       code_next;
    logic signed [ipsd_pkg::XYZ_W-1:0] sa_ext, b15_ext, x_next, y_next, z_next;

    // sign tests on u2 = s*alpha - beta/2 and u3 = -s*alpha - beta/2 in q.24
    always_comb begin
        gain_s    = $signed({1'b0, counts_per_volt});
        s_alpha   = ipsd_pkg::UQ_W'(alpha * $signed({1'b0, ipsd_pkg::SQRT3_HALF_Q16}));
        half_beta = ipsd_pkg::UQ_W'(beta) <<< 15;
        zq24      = s_alpha - half_beta;
        yq24      = -s_alpha - half_beta;
        code_next = {(yq24 > 0), (zq24 > 0), (beta > 0)};
    end

    // combine scaled terms into the three times
    always_comb begin
        sa_ext  = ipsd_pkg::XYZ_W'(sa_reg);
        b15_ext = ipsd_pkg::XYZ_W'(bk2_reg) <<< 15;
        x_next  = ipsd_pkg::XYZ_W'(bk2_reg) <<< 16;
        z_next  = sa_ext - b15_ext;
        y_next  = -sa_ext - b15_ext;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    // gain products, constant product, then the time sums
    always_ff @(posedge aclk) begin
        if (en) begin
            ak_reg    <= alpha * gain_s;
            bk_reg    <= beta * gain_s;
            code_reg  <= code_next;
            sa_reg    <= ak_reg * $signed({1'b0, ipsd_pkg::SQRT3_HALF_Q16});
            bk2_reg   <= bk_reg;
            code2_reg <= code_reg;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            code3_reg <= code2_reg;
        end
    end

    assign out_valid   = valid_reg[2];
    assign sector_code = code3_reg;
    assign x_time      = x_reg;
    assign y_time      = y_reg;
    assign z_time      = z_reg;

endmodule

[rtl/core/ipsd_duty.sv]
// per sector compare numerators, rounding, saturation and the output register
module ipsd_duty (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [ipsd_pkg::CODE_W-1:0]           sector_code,
    input  logic signed [ipsd_pkg::XYZ_W-1:0]     x_time,
    input  logic signed [ipsd_pkg::XYZ_W-1:0]     y_time,
    input  logic signed [ipsd_pkg::XYZ_W-1:0]     z_time,
    input  logic [ipsd_pkg::PER_W-1:0]            pwm_period,
    output logic                                  out_valid,
    output logic [ipsd_pkg::DUTY_W-1:0]           duty_a,
    output logic [ipsd_pkg::DUTY_W-1:0]           duty_b,
    output logic [ipsd_pkg::DUTY_W-1:0]           duty_c,
    output logic [ipsd_pkg::CODE_W-1:0]           code_out,
    output logic                                  clipped
);

    logic valid_reg;
    logic out_valid_reg;

    logic signed [ipsd_pkg::NUM_W-1:0] na_reg, nb_reg, nc_reg;
    logic [ipsd_pkg::CODE_W-1:0]       code_reg, code_out_reg;
    logic                              sec_ok_reg;
    logic [ipsd_pkg::DUTY_W-1:0]       duty_a_reg, duty_b_reg, duty_c_reg;
    logic                              clipped_reg;

    logic signed [ipsd_pkg::NUM_W-1:0] pq, xe, ye, ze, na_next, nb_next, nc_next;
    logic                              sec_ok_next;
    logic [ipsd_pkg::DUTY_W:0]         ca, cb, cc;
    logic [ipsd_pkg::DUTY_W-1:0]       duty_a_next, duty_b_next, duty_c_next;
    logic                              clipped_next;

    // drop bits below 33, then clamp to 0..period; msb of result is the clip flag
    function automatic logic [ipsd_pkg::DUTY_W:0] clamp_duty(
        input logic signed [ipsd_pkg::NUM_W-1:0] num,
        input logic [ipsd_pkg::PER_W-1:0]        per
    );
        logic [30:0] v;
        v = num[63:33];
        if (num[ipsd_pkg::NUM_W-1]) begin
            return {1'b1, {ipsd_pkg::DUTY_W{1'b0}}};
        end else if (v > {15'd0, per}) begin
            return {1'b1, per};
        end else begin
            return {1'b0, v[ipsd_pkg::DUTY_W-1:0]};
        end
    endfunction

    // period in q.32 with the rounding half already added
    always_comb begin
        pq = $signed({15'd0, {1'b0, pwm_period} + 17'd1, 32'd0});
        xe = ipsd_pkg::NUM_W'(x_time);
        ye = ipsd_pkg::NUM_W'(y_time);
        ze = ipsd_pkg::NUM_W'(z_time);
    end

    // active vector times per sector, zero vector split evenly
    always_comb begin
        sec_ok_next = 1'b1;
        na_next     = pq;
        nb_next     = pq;
        nc_next     = pq;
        case (sector_code)
            ipsd_pkg::SEC_CODE_3: begin
                na_next = pq + ze + xe;
                nb_next = pq - ze + xe;
                nc_next = pq - ze - xe;
            end
            ipsd_pkg::SEC_CODE_1: begin
                na_next = pq + ze - ye;
                nb_next = pq - ze - ye;
                nc_next = pq + ze + ye;
            end
            ipsd_pkg::SEC_CODE_5: begin
                na_next = pq - xe - ye;
                nb_next = pq + xe + ye;
                nc_next = pq - xe + ye;
            end
            ipsd_pkg::SEC_CODE_4: begin
                na_next = pq + xe + ze;
                nb_next = pq + xe - ze;
                nc_next = pq - xe - ze;
            end
            ipsd_pkg::SEC_CODE_6: begin
                na_next = pq - ye + ze;
                nb_next = pq - ye - ze;
                nc_next = pq + ye + ze;
            end
            ipsd_pkg::SEC_CODE_2: begin
                na_next = pq - ye - xe;
                nb_next = pq + ye + xe;
                nc_next = pq + ye - xe;
            end
            default: begin
                sec_ok_next = 1'b0;
            end
        endcase
    end

    // saturation, invalid sectors give zeros without clip
    always_comb begin
        ca = clamp_duty(na_reg, pwm_period);
        cb = clamp_duty(nb_reg, pwm_period);
        cc = clamp_duty(nc_reg, pwm_period);
        if (sec_ok_reg) begin
            duty_a_next  = ca[ipsd_pkg::DUTY_W-1:0];
            duty_b_next  = cb[ipsd_pkg::DUTY_W-1:0];
            duty_c_next  = cc[ipsd_pkg::DUTY_W-1:0];
            clipped_next = ca[ipsd_pkg::DUTY_W] | cb[ipsd_pkg::DUTY_W] | cc[ipsd_pkg::DUTY_W];
        end else begin
            duty_a_next  = '0;
            duty_b_next  = '0;
            duty_c_next  = '0;
            clipped_next = 1'b0;
        end
    end

    // valid bits, the last one is the output beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= in_valid;
            out_valid_reg <= valid_reg;
        end
    end

    // numerator and output registers
    always_ff @(posedge aclk) begin
        if (en) begin
            na_reg       <= na_next;
            nb_reg       <= nb_next;
            nc_reg       <= nc_next;
            code_reg     <= sector_code;
            sec_ok_reg   <= sec_ok_next;
            duty_a_reg   <= duty_a_next;
            duty_b_reg   <= duty_b_next;
            duty_c_reg   <= duty_c_next;
            code_out_reg <= code_reg;
            clipped_reg  <= clipped_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty_a    = duty_a_reg;
    assign duty_b    = duty_b_reg;
    assign duty_c    = duty_c_reg;
    assign code_out  = code_out_reg;
    assign clipped   = clipped_reg;

endmodule

[rtl/core/inverse_park_svpwm_duty_core.sv]
// inverse park transform and svpwm compare value core, top level
// throughput: one beat per cycle; the eight stage pipeline moves as a whole
// and holds while an output beat waits, so s_axis_tready follows that stall
// reset: synchronous active low aresetn clears all stage valid bits and loads
// counts_per_volt = 77594 and pwm_period = 4200
module inverse_park_svpwm_duty_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [0:0]                            cfg_index,
    input  logic [ipsd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ipsd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // elec_angle, volt_d, volt_q
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // duty_a, duty_b, duty_c, sector_code, clipped, 4 bits zero fill
    output logic [ipsd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic [ipsd_pkg::GAIN_W-1:0] counts_per_volt_reg;
    logic [ipsd_pkg::PER_W-1:0]  pwm_period_reg;

    logic en;
    logic rot_valid, scale_valid;
    logic signed [ipsd_pkg::AB_W-1:0]  alpha, beta;
    logic [ipsd_pkg::CODE_W-1:0]       code_mid, code_out;
    logic signed [ipsd_pkg::XYZ_W-1:0] x_time, y_time, z_time;
    logic [ipsd_pkg::DUTY_W-1:0]       duty_a, duty_b, duty_c;
    logic                              clipped;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_per_volt_reg <= ipsd_pkg::GAIN_RESET;
            pwm_period_reg      <= ipsd_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            case (ipsd_pkg::cfg_index_t'(cfg_index))
                ipsd_pkg::CFG_COUNTS_PER_VOLT: counts_per_volt_reg <= cfg_wdata;
                ipsd_pkg::CFG_PWM_PERIOD: pwm_period_reg <= cfg_wdata[ipsd_pkg::PER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline advances when the output beat is empty or being taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    ipsd_rot u_rot (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .elec_angle (s_axis_tdata[15:0]),
        .volt_d     ($signed(s_axis_tdata[31:16])),
        .volt_q     ($signed(s_axis_tdata[47:32])),
        .out_valid  (rot_valid),
        .alpha      (alpha),
        .beta       (beta)
    );

    ipsd_scale u_scale (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (rot_valid),
        .alpha           (alpha),
        .beta            (beta),
        .counts_per_volt (counts_per_volt_reg),
        .out_valid       (scale_valid),
        .sector_code     (code_mid),
        .x_time          (x_time),
        .y_time          (y_time),
        .z_time          (z_time)
    );

    ipsd_duty u_duty (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (scale_valid),
        .sector_code (code_mid),
        .x_time      (x_time),
        .y_time      (y_time),
        .z_time      (z_time),
        .pwm_period  (pwm_period_reg),
        .out_valid   (m_axis_tvalid),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .duty_c      (duty_c),
        .code_out    (code_out),
        .clipped     (clipped)
    );

    // pack the result beat
    assign m_axis_tdata = {4'd0, clipped, code_out, duty_c, duty_b, duty_a};

endmodule

[test/inverse_park_svpwm_duty_core_tb.sv]
// self-checking testbench for the inverse park / svpwm compare value core
`timescale 1ns / 100ps

module inverse_park_svpwm_duty_core_tb;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 80;     // long receiver hold-off
    localparam int IDLE_LIMIT   = 3000;   // watchdog, cycles with no beat on either side
    localparam int NUM_PHASES   = 8;
    localparam int RAND_PER_PHASE = 104;
    localparam int NUM_ROWS     = 20;

    // quarter wave of the sine, signed q1.14, 65 points
    localparam int SINE_QTR [0:64] = '{
        0, 402, 804, 1205, 1606, 2006, 2404, 2801,
        3196, 3590, 3981, 4370, 4756, 5139, 5520, 5897,
        6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765,
        9102, 9434, 9760, 10080, 10394, 10702, 11003, 11297,
        11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
        13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
        15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
        16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
        16384
    };

    typedef struct packed {
        logic [ipsd_pkg::DUTY_W-1:0] duty_a;
        logic [ipsd_pkg::DUTY_W-1:0] duty_b;
        logic [ipsd_pkg::DUTY_W-1:0] duty_c;
        logic [ipsd_pkg::CODE_W-1:0] sector;
        logic                        clipped;
    } duty_beat_t;

    typedef struct packed {
        logic [15:0] ang;
        logic [15:0] vd;
        logic [15:0] vq;
        logic        typed;    // expected result given in the row
        duty_beat_t  res;
    } stim_row_t;

    // directed rows, reset register values apply
    stim_row_t dir_rows [0:NUM_ROWS-1] = '{
        // zero command, no valid sector
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 3'd0, 1'b0}},
        '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, '{16'd0, 16'd0, 16'd0, 3'd0, 1'b0}},
        // full scale d axis, both sides saturate
        '{16'h0000, 16'h7FFF, 16'h0000, 1'b1,
          '{16'd4200, 16'd0, 16'd0, ipsd_pkg::SEC_CODE_2, 1'b1}},
        '{16'h0000, 16'h8000, 16'h0000, 1'b1,
          '{16'd0, 16'd4200, 16'd4200, ipsd_pkg::SEC_CODE_4, 1'b1}},
        // one point in the middle of each sector
        '{16'h1555, 16'h0400, 16'h0000, 1'b0, '0},
        '{16'h4000, 16'h0400, 16'h0000, 1'b0, '0},
        '{16'h6AAB, 16'h0400, 16'h0000, 1'b0, '0},
        '{16'h9555, 16'h0400, 16'h0000, 1'b0, '0},
        '{16'hC000, 16'h0400, 16'h0000, 1'b0, '0},
        '{16'hEAAB, 16'h0400, 16'h0000, 1'b0, '0},
        // extremes of the commands on the quadrant corners, then assorted angles and commands
        '{16'h4000, 16'h0000, 16'h7FFF, 1'b0, '0},
        '{16'h8000, 16'h7FFF, 16'h8000, 1'b0, '0},
        '{16'hC000, 16'h8000, 16'h7FFF, 1'b0, '0},
        '{16'h00FF, 16'h0001, 16'hFFFF, 1'b0, '0},
        '{16'h2000, 16'h0080, 16'h0080, 1'b0, '0},
        '{16'h5555, 16'hFF00, 16'h0100, 1'b0, '0},
        '{16'hAAAA, 16'h1234, 16'hEDCB, 1'b0, '0},
        // smallest beta on either side of zero
        '{16'h0000, 16'h0000, 16'h0001, 1'b0, '0},
        '{16'h0000, 16'h0000, 16'hFFFF, 1'b0, '0},
        '{16'h4000, 16'h0001, 16'h0000, 1'b0, '0}
    };

    logic                             aclk          = 1'b0;
    logic                             aresetn       = 1'b0;
    logic                             cfg_wr_en     = 1'b0;
    ipsd_pkg::cfg_index_t             cfg_index     = ipsd_pkg::CFG_COUNTS_PER_VOLT;
    logic [ipsd_pkg::CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ipsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // elec_angle, volt_d, volt_q
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // duty_a, duty_b, duty_c, sector_code, clipped, 4 bits zero fill
    logic [ipsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // model copy of the registers
    logic [ipsd_pkg::GAIN_W-1:0] gain_reg   = ipsd_pkg::GAIN_RESET;
    logic [ipsd_pkg::PER_W-1:0]  period_reg = ipsd_pkg::PERIOD_RESET;

    duty_beat_t duty_q [$];
    duty_beat_t want_beat;
    int  err_count = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;        // no gaps on either side
    bit  hold_req = 1'b0;
    int  rdy_hold = 0;
    int  rdy_wait = 0;

    inverse_park_svpwm_duty_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // floor((v + half) / 2^sh), rounds half up
    function automatic longint round_up_shr(input longint v, input int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    function automatic longint sine_q14(input logic [7:0] ix);
        longint mag;
        if (ix[6]) begin
            mag = SINE_QTR[64 - ix[5:0]];
        end else begin
            mag = SINE_QTR[ix[5:0]];
        end
        return ix[7] ? -mag : mag;
    endfunction

    // {clip flag, compare value} after rounding and saturation to 0..per
    function automatic logic [16:0] clamp_count(input longint num, input longint per);
        longint v;
        v = round_up_shr(num, 33);
        if (v < 0) return {1'b1, 16'd0};
        if (v > per) return {1'b1, per[15:0]};
        return {1'b0, v[15:0]};
    endfunction

    // expected compare values for one command beat under the current registers
    function automatic duty_beat_t predict_duty(input logic [15:0] ang,
                                                input logic [15:0] vd, input logic [15:0] vq);
        logic [7:0] ix;
        longint ud, uq, sn, cs, alpha, beta, zq, yq, kk, pp, pq, xt, yt, zt, na, nb, nc;
        logic [2:0] code;
        logic [16:0] ca, cb, cc;
        duty_beat_t r;
        ix    = ang[15:8];
        ud    = $signed(vd);
        uq    = $signed(vq);
        sn    = sine_q14(ix);
        cs    = sine_q14(ix + 8'd64);
        alpha = round_up_shr(ud * cs - uq * sn, 14);
        beta  = round_up_shr(uq * cs + ud * sn, 14);
        zq    = 56756 * alpha - 32768 * beta;
        yq    = -56756 * alpha - 32768 * beta;
        kk    = gain_reg;
        pp    = period_reg;
        pq    = pp <<< 32;
        xt    = beta * kk * 65536;
        yt    = yq * kk;
        zt    = zq * kk;
        code  = {yq > 0, zq > 0, beta > 0};
        na = 0; nb = 0; nc = 0;
        r  = '0;
        r.sector = code;
        case (code)
            ipsd_pkg::SEC_CODE_3: begin
                na = pq + zt + xt; nb = pq - zt + xt; nc = pq - zt - xt;
            end
            ipsd_pkg::SEC_CODE_1: begin
                na = pq + zt - yt; nb = pq - zt - yt; nc = pq + zt + yt;
            end
            ipsd_pkg::SEC_CODE_5: begin
                na = pq - xt - yt; nb = pq + xt + yt; nc = pq - xt + yt;
            end
            ipsd_pkg::SEC_CODE_4: begin
                na = pq + xt + zt; nb = pq + xt - zt; nc = pq - xt - zt;
            end
            ipsd_pkg::SEC_CODE_6: begin
                na = pq - yt + zt; nb = pq - yt - zt; nc = pq + yt + zt;
            end
            ipsd_pkg::SEC_CODE_2: begin
                na = pq - yt - xt; nb = pq + yt + xt; nc = pq + yt - xt;
            end
            default: return r;
        endcase
        ca = clamp_count(na, pp);
        cb = clamp_count(nb, pp);
        cc = clamp_count(nc, pp);
        r.duty_a  = ca[15:0];
        r.duty_b  = cb[15:0];
        r.duty_c  = cc[15:0];
        r.clipped = ca[16] | cb[16] | cc[16];
        return r;
    endfunction

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // voltage command: full range, moderate or small magnitude
    function automatic logic [15:0] rand_volt();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return w;
            3:       return {{8{w[7]}}, w[7:0]};
            default: return {{5{w[10]}}, w[10:0]};
        endcase
    endfunction

    task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // offer one command beat and hold it until accepted
    task automatic send_cmd(input logic [15:0] ang, input logic [15:0] vd, input logic [15:0] vq,
                            input bit typed, input duty_beat_t typed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vq, vd, ang};
        do @(posedge aclk); while (!s_axis_tready);
        duty_q.push_back(typed ? typed_res : predict_duty(ang, vd, vq));
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (duty_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic cfg_write(input ipsd_pkg::cfg_index_t idx,
                             input logic [ipsd_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ipsd_pkg::CFG_COUNTS_PER_VOLT: gain_reg   = data[ipsd_pkg::GAIN_W-1:0];
            ipsd_pkg::CFG_PWM_PERIOD:      period_reg = data[ipsd_pkg::PER_W-1:0];
            default: begin
            end
        endcase
    endtask

    // receiver side: random stalls plus one long hold-off on request
    always @(negedge aclk) begin
        if (rdy_hold > 0) begin
            m_axis_tready <= 1'b0;
            rdy_hold--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            rdy_hold = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (rdy_wait > 0) begin
            m_axis_tready <= 1'b0;
            rdy_wait--;
        end else begin
            m_axis_tready <= 1'b1;
            rdy_wait = pick_gap();
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (duty_q.size() == 0) begin
                err_count++;
                $display("%0t ns: unexpected result beat, expected none, got %h",
                         $time, m_axis_tdata);
            end else begin
                want_beat = duty_q.pop_front();
                check_field("duty_a", want_beat.duty_a, m_axis_tdata[15:0]);
                check_field("duty_b", want_beat.duty_b, m_axis_tdata[31:16]);
                check_field("duty_c", want_beat.duty_c, m_axis_tdata[47:32]);
                check_field("sector_code", 16'(want_beat.sector), 16'(m_axis_tdata[50:48]));
                check_field("clipped", 16'(want_beat.clipped), 16'(m_axis_tdata[51]));
                check_field("zero fill", 16'd0, 16'(m_axis_tdata[55:52]));
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus: directed rows, then random beats over several register settings
    initial begin
        logic [ipsd_pkg::GAIN_W-1:0] gain_set;
        logic [ipsd_pkg::CFG_DATA_W-1:0] per_word;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            calm = (ph % 3 == 1);
            if (ph > 0) begin
                drain();
                case (ph)
                    1: begin gain_set = '0;           per_word = 24'h00FFFF; end
                    2: begin gain_set = 24'hFFFFFF;   per_word = 24'h000001; end
                    // zero period, upper bits must be dropped
                    3: begin gain_set = 24'h012345;   per_word = 24'hFF0000; end
                    default: begin
                        gain_set = ipsd_pkg::GAIN_W'($urandom_range(20000, 300000));
                        per_word = {8'($urandom), 16'($urandom_range(500, 20000))};
                    end
                endcase
                cfg_write(ipsd_pkg::CFG_COUNTS_PER_VOLT, gain_set);
                cfg_write(ipsd_pkg::CFG_PWM_PERIOD, per_word);
            end else begin
                for (int i = 0; i < NUM_ROWS; i++) begin
                    send_cmd(dir_rows[i].ang, dir_rows[i].vd, dir_rows[i].vq,
                             dir_rows[i].typed, dir_rows[i].res);
                end
            end
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 2 && n == 30) hold_req = 1'b1;
                if (ph == 3 && n == 60) drain();
                send_cmd(16'($urandom), rand_volt(), rand_volt(), 1'b0, '0);
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
